// ----- rtl/core/brs_pkg.sv -----
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants and types for the bilinear RGBA scaler.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned MaxSourceWidthDef  = 256;
  localparam int unsigned MaxSourceHeightDef = 256;
  localparam int unsigned MaxTargetDimDef    = 4096;
  localparam int unsigned FracBits           = 16;

  localparam int unsigned CoordW = 12;
  localparam int unsigned PixW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_TGT_W = 2'd2,
    CFG_TGT_H = 2'd3
  } cfg_idx_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

// ----- rtl/core/brs_divider.sv -----
// ----------------------------------------------------------------------------
// brs_divider
// Restoring divider, one quotient bit per cycle, for the step values.
// ----------------------------------------------------------------------------
module brs_divider import brs_pkg::*; #(
  parameter int unsigned NumW = 29,
  parameter int unsigned DenW = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quot
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    trial   = {rem_r[DenW-1:0], q_r[NumW-1]};
    diff    = trial - {1'b0, den_r};
    q_nxt   = {q_r[NumW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = diff;
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      q_r   <= '0;
      rem_r <= '0;
      den_r <= '0;
    end else if (start) begin
      cnt_r <= CntW'(NumW);
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r;

endmodule

// ----- rtl/core/bilinear_rgba_image_scaler_unit.sv -----
// ----------------------------------------------------------------------------
// bilinear_rgba_image_scaler_unit
// Bilinear RGBA8 scaler over a source image held in one pixel memory.
// ----------------------------------------------------------------------------
// Write transactions (op 0) store a source pixel in a single-port memory of
// MAX_SOURCE_WIDTH x MAX_SOURCE_HEIGHT words, each rounded up to a power of
// two, addressed {row, col}; writes outside the configured source size are
// dropped. Writes are accepted back to back, one per cycle, unless held off.
// Sample transactions (op 1) map the destination coordinate through the x/y
// steps ((source size - 1) << 16) / target size, read the four neighbours
// through the one memory port, one per cycle, and blend each channel with
// 16-bit weights, rounded half up. A sample holds the input off while it forms
// the positions, picks the neighbours and makes its four memory reads. The
// next transaction is accepted while the blend pipeline and the output register
// still hold earlier work. The output register and a one-entry skid buffer
// absorb receiver stalls; the input is held off while the skid holds a pixel,
// or while the output register is full and a sample is in the blend pipeline.
// After each configuration write the steps are recomputed by bit-serial
// dividers (25 quotient bits at the default sizes); the input is held off
// until the steps are ready. Write the configuration only while no transaction
// is in flight. The memory is not cleared: reading a pixel that was never
// written gives an undefined value.
module bilinear_rgba_image_scaler_unit import brs_pkg::*; #(
  parameter int unsigned MAX_SOURCE_WIDTH  = MaxSourceWidthDef,
  parameter int unsigned MAX_SOURCE_HEIGHT = MaxSourceHeightDef,
  parameter int unsigned MAX_TARGET_DIM    = MaxTargetDimDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [11:0] col, [23:12] row, [55:24] pixel_in, [63:56] zero
  input  logic [63:0]         in_tdata,
  // [0] op
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [31:0] pixel_out
  output logic [31:0]         out_tdata
);

  localparam int unsigned XW    = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_SOURCE_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned SXW   = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int unsigned SYW   = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int unsigned SW    = (SXW > SYW) ? SXW : SYW;
  localparam int unsigned TW    = $clog2(MAX_TARGET_DIM + 1);
  localparam int unsigned NumW  = SW + FracBits;
  localparam int unsigned PosW  = CoordW + NumW;

  // ---------------- configuration ----------------
  logic [8:0]  src_w_r, src_h_r;
  logic [12:0] tgt_w_r, tgt_h_r;
  logic        recalc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= 9'd1;
      src_h_r  <= 9'd1;
      tgt_w_r  <= 13'd1;
      tgt_h_r  <= 13'd1;
      recalc_r <= 1'b0;
    end else begin
      recalc_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SRC_W: src_w_r <= cfg_data[8:0];
          CFG_SRC_H: src_h_r <= cfg_data[8:0];
          CFG_TGT_W: tgt_w_r <= cfg_data;
          CFG_TGT_H: tgt_h_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // clamp a size to 1..max
  logic [SXW-1:0] eff_sw;
  logic [SYW-1:0] eff_sh;
  logic [TW-1:0]  eff_tw, eff_th;

  always_comb begin
    if (src_w_r == '0) eff_sw = SXW'(1);
    else if (32'(src_w_r) > MAX_SOURCE_WIDTH) eff_sw = SXW'(MAX_SOURCE_WIDTH);
    else eff_sw = SXW'(src_w_r);
    if (src_h_r == '0) eff_sh = SYW'(1);
    else if (32'(src_h_r) > MAX_SOURCE_HEIGHT) eff_sh = SYW'(MAX_SOURCE_HEIGHT);
    else eff_sh = SYW'(src_h_r);
    if (tgt_w_r == '0) eff_tw = TW'(1);
    else if (32'(tgt_w_r) > MAX_TARGET_DIM) eff_tw = TW'(MAX_TARGET_DIM);
    else eff_tw = TW'(tgt_w_r);
    if (tgt_h_r == '0) eff_th = TW'(1);
    else if (32'(tgt_h_r) > MAX_TARGET_DIM) eff_th = TW'(MAX_TARGET_DIM);
    else eff_th = TW'(tgt_h_r);
  end

  logic [XW-1:0] last_x;
  logic [YW-1:0] last_y;
  assign last_x = XW'(eff_sw - 1'b1);
  assign last_y = YW'(eff_sh - 1'b1);

  // step dividers
  logic            dx_busy, dy_busy;
  logic [NumW-1:0] x_step, y_step;

  brs_divider #(.NumW(NumW), .DenW(TW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(recalc_r),
    .num({SW'(last_x), {FracBits{1'b0}}}), .den(eff_tw),
    .busy(dx_busy), .quot(x_step));

  brs_divider #(.NumW(NumW), .DenW(TW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(recalc_r),
    .num({SW'(last_y), {FracBits{1'b0}}}), .den(eff_th),
    .busy(dy_busy), .quot(y_step));

  // ---------------- input decode ----------------
  logic               in_op;
  logic [CoordW-1:0]  in_col, in_row;
  logic [PixW-1:0]    in_pix;
  assign in_op  = in_tuser;
  assign in_col = in_tdata[11:0];
  assign in_row = in_tdata[23:12];
  assign in_pix = in_tdata[55:24];

  // Sequencer: fetch count 0 means the memory port is free.
  logic [2:0] fetch_r;
  logic       in_fire;
  logic       pipe_room;
  assign in_fire   = in_tvalid && in_tready;

  // stage A: positions (one multiplier per axis)
  logic              a_vld_r;
  logic [PosW-1:0]   posx_r, posy_r;

  // stage B: neighbour indices
  logic [XW-1:0]       x0_r, x1_r;
  logic [YW-1:0]       y0_r, y1_r;
  logic [FracBits-1:0] fx_r, fy_r;

  // hold off for a sample, no output room, a register write or a step recompute
  always_comb begin
    in_tready = (fetch_r == '0) && !a_vld_r && pipe_room && !dx_busy && !dy_busy &&
                !recalc_r && !cfg_we;
  end

  logic              do_write;
  assign do_write = in_fire && (in_op == OP_WRITE) &&
                    (32'(in_col) < 32'(eff_sw)) && (32'(in_row) < 32'(eff_sh));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_fire && (in_op == OP_SAMPLE);
    end
    posx_r <= PosW'(in_col) * PosW'(x_step);
    posy_r <= PosW'(in_row) * PosW'(y_step);
  end

  // locate: split a position into index pair and fraction
  logic [PosW-FracBits-1:0] ipx, ipy;
  assign ipx = posx_r[PosW-1:FracBits];
  assign ipy = posy_r[PosW-1:FracBits];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_r <= '0;
    end else if (a_vld_r) begin
      fetch_r <= 3'd4;
    end else if (fetch_r != '0) begin
      fetch_r <= fetch_r - 1'b1;
    end
    if (a_vld_r) begin
      if (ipx >= (PosW-FracBits)'(last_x)) begin
        x0_r <= last_x;
        x1_r <= last_x;
        fx_r <= (ipx == (PosW-FracBits)'(last_x)) ? posx_r[FracBits-1:0] : '0;
      end else begin
        x0_r <= XW'(ipx);
        x1_r <= XW'(ipx) + 1'b1;
        fx_r <= posx_r[FracBits-1:0];
      end
      if (ipy >= (PosW-FracBits)'(last_y)) begin
        y0_r <= last_y;
        y1_r <= last_y;
        fy_r <= (ipy == (PosW-FracBits)'(last_y)) ? posy_r[FracBits-1:0] : '0;
      end else begin
        y0_r <= YW'(ipy);
        y1_r <= YW'(ipy) + 1'b1;
        fy_r <= posy_r[FracBits-1:0];
      end
    end
  end

  // ---------------- pixel memory ----------------
  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;

  assign wr_addr = {YW'(in_row), XW'(in_col)};
  assign rd_en   = (fetch_r != '0);

  always_comb begin
    unique case (fetch_r)
      3'd4:    rd_addr = {y0_r, x0_r};
      3'd3:    rd_addr = {y0_r, x1_r};
      3'd2:    rd_addr = {y1_r, x0_r};
      default: rd_addr = {y1_r, x1_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= in_pix;
    end else if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // capture four neighbours; data of fetch k arrives in the cycle after it
  logic [2:0]      cap_r;
  logic [PixW-1:0] tl_r, tr_r, bl_r;
  logic [FracBits-1:0] fx_h_r, fy_h_r;
  logic            c_vld_r;
  logic [PixW-1:0] br_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      c_vld_r <= 1'b0;
    end else begin
      cap_r   <= fetch_r;
      c_vld_r <= (cap_r == 3'd1);
    end
    unique case (cap_r)
      3'd4: tl_r <= rd_data_r;
      3'd3: tr_r <= rd_data_r;
      3'd2: bl_r <= rd_data_r;
      default: ;
    endcase
    if (cap_r == 3'd4) begin
      fx_h_r <= fx_r;
      fy_h_r <= fy_r;
    end
  end
  assign br_w = rd_data_r;

  // blend stage 1: horizontal
  logic [FracBits:0]      one_fx, one_fy;
  logic [3:0][24:0]       top_r, bot_r;
  logic [FracBits-1:0]    fy_d_r;
  logic                   h_vld_r;

  assign one_fx = (FracBits+1)'(1 << FracBits) - (FracBits+1)'(fx_h_r);
  assign one_fy = (FracBits+1)'(1 << FracBits) - (FracBits+1)'(fy_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else        h_vld_r <= (cap_r == 3'd1);
    if (cap_r == 3'd1) begin
      for (int ch = 0; ch < 4; ch++) begin
        top_r[ch] <= 25'(tl_r[ch*8 +: 8] * one_fx) + 25'(tr_r[ch*8 +: 8] * fx_h_r);
        bot_r[ch] <= 25'(bl_r[ch*8 +: 8] * one_fx) + 25'(br_w[ch*8 +: 8] * fx_h_r);
      end
      fy_d_r <= fy_h_r;
    end
  end

  // blend stage 2: vertical, round half up
  logic [3:0][41:0] v_w;
  logic [31:0]      blend_w;
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      v_w[ch] = 42'(top_r[ch]) * 42'(one_fy) + 42'(bot_r[ch]) * 42'(fy_d_r)
              + 42'h0_8000_0000;
      blend_w[ch*8 +: 8] = (v_w[ch][41:32] > 10'd255) ? 8'hFF : v_w[ch][39:32];
    end
  end

  // output register with one-entry skid so the pipeline never stalls
  logic        ov_r, sk_v_r;
  logic [31:0] od_r, sk_d_r;

  // room: at most one sample is in flight beyond the output slots
  assign pipe_room = !sk_v_r && !(ov_r && (c_vld_r || h_vld_r || cap_r != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      if (!ov_r || out_tready) begin
        if (sk_v_r) begin
          ov_r   <= 1'b1;
          od_r   <= sk_d_r;
          sk_v_r <= h_vld_r;
          sk_d_r <= blend_w;
        end else begin
          ov_r <= h_vld_r;
          od_r <= blend_w;
        end
      end else if (h_vld_r) begin
        sk_v_r <= 1'b1;
        sk_d_r <= blend_w;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // assertions
  a_skid_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_v_r && ov_r && !out_tready) |-> !h_vld_r)
    else $error("skid overrun");
  a_no_write_during_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (fetch_r != '0) |-> !do_write)
    else $error("write collides with fetch");
  a_fetch_seq: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |=> (fetch_r == 3'd4))
    else $error("fetch did not start");

endmodule

// ----- dv/bilinear_rgba_image_scaler_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_rgba_image_scaler_unit_test
// Self-checking bench for the bilinear RGBA8 scaler. Runs phases of source and
// target sizes, fills the neighbours of each sample before sampling it, and
// checks every output pixel against a bit-exact in-bench interpolator.
// ----------------------------------------------------------------------------
module bilinear_rgba_image_scaler_unit_test;
  import brs_pkg::*;

  localparam int unsigned MemW      = 256;
  localparam int unsigned MemH      = 256;
  localparam int unsigned TgtMax    = 4096;
  localparam int unsigned CycLimit  = 600000;
  localparam int unsigned SettleCyc = 64;

  typedef struct packed {
    logic        op;
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] pix;
  } scaler_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [63:0]         in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;

  bilinear_rgba_image_scaler_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // Interpolator state: its own copy of the registers, steps and source image.
  bit [8:0]  src_w_reg, src_h_reg;
  bit [12:0] tgt_w_reg, tgt_h_reg;
  bit [31:0] x_step, y_step;
  bit [31:0] src_image [0:MemW*MemH-1];
  // Which addresses the stimulus has already filled, tracked at generation
  bit        pix_filled [0:MemW*MemH-1];

  scaler_item_t pending_items[$];
  bit [31:0]    expected_pixels[$];
  int unsigned  cycle_cnt = 0;
  int unsigned  mismatch_cnt = 0;
  bit           took = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned eff_src_w();
    return clamp_dim(src_w_reg, MemW);
  endfunction

  function automatic int unsigned eff_src_h();
    return clamp_dim(src_h_reg, MemH);
  endfunction

  function automatic void recompute_steps();
    bit [63:0] nx, ny;
    nx = 64'(eff_src_w() - 1) << FracBits;
    ny = 64'(eff_src_h() - 1) << FracBits;
    x_step = 32'(nx / clamp_dim(tgt_w_reg, TgtMax));
    y_step = 32'(ny / clamp_dim(tgt_h_reg, TgtMax));
  endfunction

  // Split a destination coordinate into neighbour, next neighbour and fraction;
  // saturate past the last source pixel with a zero fraction.
  function automatic void locate(input bit [11:0] coord, input bit [31:0] step,
                                 input int unsigned size, output int unsigned i0,
                                 output int unsigned i1, output bit [16:0] frac);
    bit [63:0] pos, ip;
    pos = 64'(coord) * 64'(step);
    ip  = pos >> FracBits;
    if (ip >= size - 1) begin
      i0 = size - 1;
      i1 = size - 1;
      frac = (ip == size - 1) ? 17'(pos[15:0]) : 17'd0;
    end else begin
      i0 = 32'(ip);
      i1 = 32'(ip) + 1;
      frac = 17'(pos[15:0]);
    end
  endfunction

  function automatic bit [31:0] blend_sample(bit [11:0] col, bit [11:0] row);
    int unsigned x0, x1, y0, y1;
    bit [16:0]   fx, fy;
    bit [31:0]   tl, tr, bl, br, res;
    bit [63:0]   a, b, c, d, top, bot, v;
    locate(col, x_step, eff_src_w(), x0, x1, fx);
    locate(row, y_step, eff_src_h(), y0, y1, fy);
    tl = src_image[y0*MemW + x0];
    tr = src_image[y0*MemW + x1];
    bl = src_image[y1*MemW + x0];
    br = src_image[y1*MemW + x1];
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      a = 64'(tl[ch*8 +: 8]);
      b = 64'(tr[ch*8 +: 8]);
      c = 64'(bl[ch*8 +: 8]);
      d = 64'(br[ch*8 +: 8]);
      top = a * (64'h10000 - fx) + b * fx;
      bot = c * (64'h10000 - fx) + d * fx;
      v = top * (64'h10000 - fy) + bot * fy;
      v = (v + (64'd1 << 31)) >> 32;
      res[ch*8 +: 8] = (v > 255) ? 8'hFF : v[7:0];
    end
    return res;
  endfunction

  function automatic void apply_item(scaler_item_t it);
    if (it.op == OP_WRITE) begin
      if (it.col < eff_src_w() && it.row < eff_src_h())
        src_image[it.row*MemW + it.col] = it.pix;
    end else begin
      expected_pixels.push_back(blend_sample(it.col, it.row));
    end
  endfunction

  // Stimulus helpers: these run while the block is idle between phases, so the
  // interpolator's steps already match the phase being generated.
  function automatic void queue_write(bit [11:0] col, bit [11:0] row, bit [31:0] pix);
    scaler_item_t it;
    it = '{op: OP_WRITE, col: col, row: row, pix: pix};
    pending_items.push_back(it);
    if (col < eff_src_w() && row < eff_src_h()) pix_filled[row*MemW + col] = 1'b1;
  endfunction

  function automatic void queue_sample(bit [11:0] col, bit [11:0] row);
    int unsigned x0, x1, y0, y1;
    bit [16:0]   fx, fy;
    scaler_item_t it;
    locate(col, x_step, eff_src_w(), x0, x1, fx);
    locate(row, y_step, eff_src_h(), y0, y1, fy);
    // Fill any neighbour never written so no undefined pixel is read
    if (!pix_filled[y0*MemW + x0]) queue_write(12'(x0), 12'(y0), $urandom);
    if (!pix_filled[y0*MemW + x1]) queue_write(12'(x1), 12'(y0), $urandom);
    if (!pix_filled[y1*MemW + x0]) queue_write(12'(x0), 12'(y1), $urandom);
    if (!pix_filled[y1*MemW + x1]) queue_write(12'(x1), 12'(y1), $urandom);
    it = '{op: OP_SAMPLE, col: col, row: row, pix: $urandom};
    pending_items.push_back(it);
  endfunction

  function automatic bit [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_random(int unsigned n);
    int unsigned tw, th;
    tw = clamp_dim(tgt_w_reg, TgtMax);
    th = clamp_dim(tgt_h_reg, TgtMax);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: queue_write(12'($urandom_range(0, eff_src_w() - 1)),
                             12'($urandom_range(0, eff_src_h() - 1)), rand_pixel());
        3:       queue_write(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                             rand_pixel());
        4:       queue_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        default: queue_sample(12'($urandom_range(0, tw - 1)),
                              12'($urandom_range(0, th - 1)));
      endcase
    end
  endfunction

  // Wait until every transaction has gone through and the block has drained.
  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_pixels.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait for idle, write all four sizes, then let the step dividers settle.
  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                           int unsigned th);
    wait_idle();
    write_reg(CFG_SRC_W, sw);
    write_reg(CFG_SRC_H, sh);
    write_reg(CFG_TGT_W, tw);
    write_reg(CFG_TGT_H, th);
    repeat (SettleCyc) @(negedge clk);
  endtask

  // Input side: predict on every accepted transaction, and count cycles.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycLimit) begin
      $display("** bilinear_rgba_image_scaler_unit: FAILED **");
      $finish;
    end
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_SRC_W: src_w_reg = cfg_data[8:0];
        CFG_SRC_H: src_h_reg = cfg_data[8:0];
        CFG_TGT_W: tgt_w_reg = cfg_data;
        CFG_TGT_H: tgt_h_reg = cfg_data;
        default: ;
      endcase
      recompute_steps();
    end
    if (rst_n && in_tvalid && in_tready) begin
      apply_item(pending_items.pop_front());
      took = 1'b1;
    end
  end

  // Driver: bursts of random length separated by random gaps; hold the current
  // transaction until it is taken.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !took) begin
        // hold
      end else if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {8'h00, pending_items[0].pix, pending_items[0].row,
                      pending_items[0].col};
        in_tuser  <= pending_items[0].op;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
      took = 1'b0;
    end
  end

  // Receiver: its own stall pattern, set by cycle count bits 9:8, plus up to two
  // long hold-offs, each started while plenty of transactions are still queued.
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  always @(negedge clk) begin
    if (hold_left == 0 && pending_items.size() > 40 &&
        ((holds_done == 0 && cycle_cnt >= 1000) ||
         (holds_done == 1 && cycle_cnt >= 6000))) begin
      hold_left = 400;
      holds_done = holds_done + 1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (cycle_cnt[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= $urandom_range(0, 1);
        2'd2: out_tready <= ($urandom_range(0, 9) != 0);
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Monitor: compare each accepted pixel with the oldest expected one.
  always @(posedge clk) begin
    bit [31:0] exp_pix;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("unexpected pixel %08h at cycle %0d", out_tdata, cycle_cnt);
      end else begin
        exp_pix = expected_pixels.pop_front();
        if (out_tdata !== exp_pix) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("pixel mismatch: expected %08h, got %08h at cycle %0d",
                     exp_pix, out_tdata, cycle_cnt);
        end
      end
    end
  end

  initial begin
    src_w_reg = 1;
    src_h_reg = 1;
    tgt_w_reg = 1;
    tgt_h_reg = 1;
    recompute_steps();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (SettleCyc) @(negedge clk);

    // Directed: reset sizes, a 1 x 1 source sampled inside and far outside
    queue_write(0, 0, 32'hFFFF_FFFF);
    queue_sample(0, 0);
    queue_sample(12'hFFF, 12'hFFF);
    queue_write(12'hFFF, 12'hFFF, 32'h1234_5678);   // dropped: outside source
    queue_sample(1, 0);

    // Directed: small upscale with extreme pixels and corners
    set_sizes(2, 2, 4, 4);
    queue_write(0, 0, 32'h0000_0000);
    queue_write(1, 0, 32'hFFFF_FFFF);
    queue_write(0, 1, 32'hFF00_FF00);
    queue_write(1, 1, 32'h00FF_00FF);
    queue_write(2, 0, 32'hDEAD_BEEF);               // dropped: col past width
    queue_write(0, 2, 32'hDEAD_BEEF);               // dropped: row past height
    queue_write(12'hAAA, 12'h555, 32'hA5A5_A5A5);   // dropped
    queue_sample(0, 0);
    queue_sample(1, 1);
    queue_sample(2, 3);
    queue_sample(3, 3);
    queue_sample(4, 4);                             // outside target
    queue_sample(12'hFFF, 12'h000);
    queue_sample(12'h555, 12'hAAA);

    // Directed: largest source and target; sizes of zero; oversized registers
    set_sizes(256, 256, 4096, 4096);
    queue_sample(4095, 4095);
    queue_sample(0, 0);
    queue_sample(2047, 1);
    set_sizes(0, 0, 0, 0);
    queue_sample(0, 0);
    queue_sample(12'hFFF, 12'hFFF);
    set_sizes(511, 300, 8191, 5000);
    queue_sample(4095, 4095);
    queue_sample(12'h800, 12'h001);
    queue_random(60);

    // Random phases, mostly small sizes
    set_sizes(4, 3, 7, 5);
    queue_random(120);
    set_sizes(3, 5, 2, 1);        // downscale
    queue_random(100);
    set_sizes($urandom_range(1, 16), $urandom_range(1, 16),
              $urandom_range(1, 40), $urandom_range(1, 40));
    queue_random(120);
    set_sizes(256, 2, 1, 4096);
    queue_random(80);
    set_sizes($urandom_range(1, 8), $urandom_range(1, 8),
              $urandom_range(1, 8191), $urandom_range(1, 8191));
    queue_random(120);
    set_sizes(1, 256, 4096, 1);
    queue_random(80);
    set_sizes($urandom_range(2, 12), $urandom_range(2, 12),
              $urandom_range(2, 24), $urandom_range(2, 24));
    queue_random(120);

    wait_idle();
    if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
      $display("** bilinear_rgba_image_scaler_unit: PASSED **");
    end else begin
      $display("** bilinear_rgba_image_scaler_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/brs_pkg.sv
rtl/core/brs_divider.sv
rtl/core/bilinear_rgba_image_scaler_unit.sv
dv/bilinear_rgba_image_scaler_unit_test.sv
